// ===== src/fdc32c_pkg.sv =====
// Shared types, constants and the CRC-32C byte update for the frame deframer.
`default_nettype none

package fdc32c_pkg;

  localparam int unsigned HeaderBytes = 20;
  localparam int unsigned HdrCntW     = 5;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = 24;
  localparam int unsigned VersionW    = 16;
  localparam int unsigned MaxLenW     = 24;
  localparam int unsigned OutDataW    = 104;

  // Header byte positions
  localparam logic [HdrCntW-1:0] PosVersion = 5'd4;
  localparam logic [HdrCntW-1:0] PosType    = 5'd6;
  localparam logic [HdrCntW-1:0] PosFlags   = 5'd8;
  localparam logic [HdrCntW-1:0] PosLength  = 5'd12;
  localparam logic [HdrCntW-1:0] PosCrc     = 5'd16;
  localparam logic [HdrCntW-1:0] PosLast    = 5'd19;

  localparam logic [31:0] FrameMagic = {8'h54, 8'h45, 8'h46, 8'h31};
  localparam logic [31:0] CrcPoly    = 32'h82F6_3B78;
  localparam logic [31:0] CrcInit    = 32'hFFFF_FFFF;

  localparam logic [CfgIdxW-1:0] CfgSupportedVersion = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxPayload       = 1'd1;

  typedef enum logic [1:0] {
    PhHeader  = 2'd0,
    PhPayload = 2'd1,
    PhError   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    KindHeader  = 2'd0,
    KindPayload = 2'd1,
    KindError   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StBadMagic = 3'd1,
    StBadVer   = 3'd2,
    StTooLong  = 3'd3,
    StCrcErr   = 3'd4
  } status_e;

  typedef struct packed {
    kind_e        kind;
    logic [7:0]   pbyte;
    logic [15:0]  version;
    logic [15:0]  ftype;
    logic [31:0]  flags;
    logic [23:0]  length;
    logic         last;
    status_e      status;
  } res_t;

  // Reflected CRC-32C, one byte
  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/frame_deframer_crc32c_check.sv =====
// Frame deframer: header parse and checks, payload pass-through with CRC-32C check.
//
// Usage: received bytes enter on the s_axis channel, one byte per transaction.
// Each frame is a 20-byte big-endian header (magic, version, type, flags,
// length, CRC-32C) followed by the payload. The last header byte gives one
// header-accepted or error result; each payload byte gives one payload result,
// the last of a frame with tlast set and a CRC status. Any error is terminal:
// later bytes are taken and dropped until reset.
// Each result is registered in the output register, or in the skid register while
// the output is held. Throughput: one byte per cycle while s_axis_tready is high;
// all per-byte work (header capture, checks, byte-wise CRC update, counters) sits
// between the state registers and a two-deep output stage.
// When the receiver stalls, the output register and a skid register hold up
// to two results; s_axis_tready drops only once the skid register is full.
// Reset: gathering a header, supported_version = 1, max_payload = 65536,
// output empty. Configuration writes take effect on the next cycle; the user must
// make them only while the block is idle, which the block itself does not enforce.
`default_nettype none

module frame_deframer_crc32c_check
  import fdc32c_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 24
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // cfg write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [CfgDataW-1:0]   cfg_wdata_i,
  // byte stream in
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,   // [7:0] rx_byte
  // results out
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [7:0] payload_byte, [23:8] frame_version, [39:24] frame_type,
  // [71:40] frame_flags, [95:72] payload_length, [98:96] status, rest zero
  output logic [OutDataW-1:0]        m_axis_tdata,
  output logic [1:0]                 m_axis_tuser,   // [1:0] result_kind
  output logic                       m_axis_tlast    // frame_last
);

  localparam int unsigned LenW = (LENGTH_BITS < MaxLenW) ? LENGTH_BITS : MaxLenW;
  localparam logic [31:0] LenMask = 32'((64'd1 << LENGTH_BITS) - 64'd1);

  // configuration
  logic [VersionW-1:0] sup_ver_q;
  logic [MaxLenW-1:0]  max_len_q;

  // frame state
  phase_e              phase_q, phase_d;
  logic [HdrCntW-1:0]  hdr_cnt_q, hdr_cnt_d;
  logic [31:0]         magic_q, magic_d;
  logic [15:0]         version_q, version_d;
  logic [15:0]         ftype_q, ftype_d;
  logic [31:0]         flags_q, flags_d;
  logic [31:0]         length_q, length_d;
  logic [31:0]         exp_crc_q, exp_crc_d;
  logic [LenW-1:0]     left_q, left_d;
  logic [31:0]         crc_q, crc_d;

  // output stage
  logic                out_v_q, skid_v_q;
  res_t                out_q, skid_q;
  res_t                res;
  logic                res_valid;
  logic                s_fire, out_fire;
  logic [7:0]          b;

  assign s_axis_tready = !skid_v_q;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_fire      = out_v_q && m_axis_tready;
  assign b             = s_axis_tdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sup_ver_q <= 16'd1;
      max_len_q <= 24'd65536;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSupportedVersion: sup_ver_q <= cfg_wdata_i[VersionW-1:0];
        CfgMaxPayload:       max_len_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d   = phase_q;
    hdr_cnt_d = hdr_cnt_q;
    magic_d   = magic_q;
    version_d = version_q;
    ftype_d   = ftype_q;
    flags_d   = flags_q;
    length_d  = length_q;
    exp_crc_d = exp_crc_q;
    left_d    = left_q;
    crc_d     = crc_q;
    res_valid = 1'b0;
    res.kind  = KindHeader;
    res.pbyte = 8'd0;
    res.last  = 1'b0;
    res.status = StOk;

    if (s_fire) begin
      case (phase_q)
        PhHeader: begin
          if (hdr_cnt_q < PosVersion)      magic_d   = {magic_q[23:0], b};
          else if (hdr_cnt_q < PosType)    version_d = {version_q[7:0], b};
          else if (hdr_cnt_q < PosFlags)   ftype_d   = {ftype_q[7:0], b};
          else if (hdr_cnt_q < PosLength)  flags_d   = {flags_q[23:0], b};
          else if (hdr_cnt_q < PosCrc)     length_d  = {length_q[23:0], b};
          else                             exp_crc_d = {exp_crc_q[23:0], b};

          if (hdr_cnt_q != PosLast) begin
            hdr_cnt_d = hdr_cnt_q + 5'd1;
          end else begin
            hdr_cnt_d = '0;
            res_valid = 1'b1;
            res.last  = 1'b1;
            if (magic_d != FrameMagic) begin
              phase_d    = PhError;
              res.kind   = KindError;
              res.status = StBadMagic;
            end else if (version_d == 16'd0 || version_d > sup_ver_q) begin
              phase_d    = PhError;
              res.kind   = KindError;
              res.status = StBadVer;
            end else if (length_d > {8'd0, max_len_q} || (length_d & ~LenMask) != 32'd0) begin
              phase_d    = PhError;
              res.kind   = KindError;
              res.status = StTooLong;
            end else begin
              crc_d = CrcInit;
              if (length_d == 32'd0) begin
                // empty payload: CRC of no data is zero
                if (exp_crc_d != 32'd0) begin
                  phase_d    = PhError;
                  res.kind   = KindError;
                  res.status = StCrcErr;
                end
              end else begin
                left_d   = length_d[LenW-1:0];
                phase_d  = PhPayload;
                res.last = 1'b0;
              end
            end
          end
        end
        PhPayload: begin
          crc_d     = crc32c_byte(crc_q, b);
          res_valid = 1'b1;
          res.kind  = KindPayload;
          res.pbyte = b;
          if (left_q > LenW'(1)) begin
            left_d = left_q - LenW'(1);
          end else begin
            left_d   = '0;
            res.last = 1'b1;
            if ((crc_d ^ CrcInit) != exp_crc_q) begin
              phase_d    = PhError;
              res.status = StCrcErr;
            end else begin
              phase_d   = PhHeader;
              hdr_cnt_d = '0;
            end
          end
        end
        default: ;
      endcase
    end

    res.version = version_d;
    res.ftype   = ftype_d;
    res.flags   = flags_d;
    res.length  = 24'(length_d & LenMask);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHeader;
      hdr_cnt_q <= '0;
      magic_q   <= '0;
      version_q <= '0;
      ftype_q   <= '0;
      flags_q   <= '0;
      length_q  <= '0;
      exp_crc_q <= '0;
      left_q    <= '0;
      crc_q     <= CrcInit;
    end else begin
      phase_q   <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      magic_q   <= magic_d;
      version_q <= version_d;
      ftype_q   <= ftype_d;
      flags_q   <= flags_d;
      length_q  <= length_d;
      exp_crc_q <= exp_crc_d;
      left_q    <= left_d;
      crc_q     <= crc_d;
    end
  end

  // output register plus skid; a new result only arrives while skid is empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_fire) begin
        skid_v_q <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_v_q || out_fire) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (res_valid) begin
      if (!out_v_q || out_fire) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {5'd0, out_q.status, out_q.length, out_q.flags,
                          out_q.ftype, out_q.version, out_q.pbyte};
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;

  // checks
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q) else $error("skid holds a result while output is empty");

  a_error_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhError) |-> !res_valid) else $error("result produced after terminal error");

  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhError) |=> (phase_q == PhError)) else $error("left error phase without reset");

  a_hdr_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_cnt_q <= PosLast) else $error("header byte count out of range");

  a_payload_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhPayload) |-> (left_q != '0)) else $error("payload phase with no bytes left");

endmodule

`default_nettype wire

// ===== tb/sv/tb_frame_deframer_crc32c_check.sv =====
// Self-checking testbench for the frame deframer with CRC-32C payload check.
`timescale 1ns / 100ps

module tb_frame_deframer_crc32c_check;
  import fdc32c_pkg::*;

  typedef logic [7:0] octet_q_t[$];

  // Mirrors the deframer: header capture, checks, payload CRC; holds results still due.
  class frame_scoreboard;
    logic [15:0]        sup_ver;
    logic [23:0]        max_len;
    phase_e             ph;
    logic [HdrCntW-1:0] hdr_pos;
    logic [31:0]        magic_acc;
    logic [15:0]        ver_acc;
    logic [15:0]        type_acc;
    logic [31:0]        flags_acc;
    logic [31:0]        len_acc;
    logic [31:0]        crc_acc;
    logic [23:0]        remaining;
    logic [31:0]        crc_run;
    res_t               due_q[$];
    int unsigned        errors;

    function new();
      sup_ver   = 16'd1;
      max_len   = 24'd65536;
      ph        = PhHeader;
      hdr_pos   = '0;
      magic_acc = '0;
      ver_acc   = '0;
      type_acc  = '0;
      flags_acc = '0;
      len_acc   = '0;
      crc_acc   = '0;
      remaining = '0;
      crc_run   = '1;
      errors    = 0;
    endfunction

    function int outstanding();
      return due_q.size();
    endfunction

    // Bit-serial form of the reflected CRC-32C update
    function logic [31:0] crc_next(logic [31:0] c, logic [7:0] b);
      logic fb;
      for (int i = 0; i < 8; i++) begin
        fb = c[0] ^ b[i];
        c  = c >> 1;
        if (fb) c = c ^ CrcPoly;
      end
      return c;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      if (idx == CfgSupportedVersion) sup_ver = val[15:0];
      else if (idx == CfgMaxPayload) max_len = val;
    endfunction

    function void push_result(kind_e k, logic [7:0] pb, logic last, status_e st);
      res_t r;
      r.kind    = k;
      r.pbyte   = pb;
      r.version = ver_acc;
      r.ftype   = type_acc;
      r.flags   = flags_acc;
      r.length  = len_acc[23:0];
      r.last    = last;
      r.status  = st;
      due_q.push_back(r);
    endfunction

    function void note_byte(logic [7:0] b);
      case (ph)
        PhHeader: begin
          if (hdr_pos < PosVersion) magic_acc = {magic_acc[23:0], b};
          else if (hdr_pos < PosType) ver_acc = {ver_acc[7:0], b};
          else if (hdr_pos < PosFlags) type_acc = {type_acc[7:0], b};
          else if (hdr_pos < PosLength) flags_acc = {flags_acc[23:0], b};
          else if (hdr_pos < PosCrc) len_acc = {len_acc[23:0], b};
          else crc_acc = {crc_acc[23:0], b};
          if (hdr_pos < PosLast) begin
            hdr_pos++;
            return;
          end
          hdr_pos = '0;
          if (magic_acc != FrameMagic) begin
            ph = PhError;
            push_result(KindError, 8'd0, 1'b1, StBadMagic);
          end else if (ver_acc == 16'd0 || ver_acc > sup_ver) begin
            ph = PhError;
            push_result(KindError, 8'd0, 1'b1, StBadVer);
          end else if (len_acc > {8'd0, max_len}) begin
            // also catches lengths wider than 24 bits
            ph = PhError;
            push_result(KindError, 8'd0, 1'b1, StTooLong);
          end else begin
            crc_run = '1;
            if (len_acc == 32'd0) begin
              // empty payload: CRC of no data is zero
              if (crc_acc != 32'd0) begin
                ph = PhError;
                push_result(KindError, 8'd0, 1'b1, StCrcErr);
              end else begin
                push_result(KindHeader, 8'd0, 1'b1, StOk);
              end
            end else begin
              remaining = len_acc[23:0];
              ph        = PhPayload;
              push_result(KindHeader, 8'd0, 1'b0, StOk);
            end
          end
        end
        PhPayload: begin
          crc_run = crc_next(crc_run, b);
          if (remaining > 24'd1) begin
            remaining--;
            push_result(KindPayload, b, 1'b0, StOk);
          end else begin
            remaining = '0;
            if (~crc_run != crc_acc) begin
              ph = PhError;
              push_result(KindPayload, b, 1'b1, StCrcErr);
            end else begin
              ph      = PhHeader;
              hdr_pos = '0;
              push_result(KindPayload, b, 1'b1, StOk);
            end
          end
        end
        default: ;  // error phase swallows everything
      endcase
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want != got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (due_q.size() == 0) begin
        $error("result_kind: expected no result, got 0x%0h", got.kind);
        errors++;
        return;
      end
      want = due_q.pop_front();
      compare("result_kind", want.kind, got.kind);
      compare("payload_byte", want.pbyte, got.pbyte);
      compare("frame_version", want.version, got.version);
      compare("frame_type", want.ftype, got.ftype);
      compare("frame_flags", want.flags, got.flags);
      compare("payload_length", want.length, got.length);
      compare("frame_last", want.last, got.last);
      compare("status", want.status, got.status);
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]    cfg_idx_i = '0;
  logic [CfgDataW-1:0]   cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OutDataW-1:0]   m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  m_axis_tlast;

  frame_scoreboard sb = new();

  logic [15:0] cur_sv = 16'd1;
  logic [23:0] cur_mp = 24'd65536;
  int unsigned bytes_sent = 0;
  int unsigned send_pct = 0;
  int unsigned recv_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;

  frame_deframer_crc32c_check dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: random back-pressure, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = 300;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_pct);
    end
  end

  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind    = kind_e'(m_axis_tuser);
      got.pbyte   = m_axis_tdata[7:0];
      got.version = m_axis_tdata[23:8];
      got.ftype   = m_axis_tdata[39:24];
      got.flags   = m_axis_tdata[71:40];
      got.length  = m_axis_tdata[95:72];
      got.last    = m_axis_tlast;
      got.status  = status_e'(m_axis_tdata[98:96]);
      sb.check_result(got);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
    sb.note_byte(b);
  endtask

  // Drop valid, then wait until every result is in and the pipeline has settled
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    sb.set_reg(idx, val);
    if (idx == CfgSupportedVersion) cur_sv = val[15:0];
    else cur_mp = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic octet_q_t rand_payload(input int unsigned n);
    octet_q_t q;
    repeat (n) q.push_back(8'($urandom));
    return q;
  endfunction

  task automatic send_frame(input logic [31:0] magic, input logic [15:0] ver,
                            input logic [15:0] ftype, input logic [31:0] flags,
                            input logic [31:0] len, input octet_q_t pay,
                            input logic [31:0] crc_flip);
    logic [31:0]  crc;
    logic [159:0] hdr;
    crc = '1;
    foreach (pay[i]) crc = sb.crc_next(crc, pay[i]);
    crc = ~crc ^ crc_flip;
    hdr = {magic, ver, ftype, flags, len, crc};
    for (int i = 19; i >= 0; i--) send_byte(hdr[i*8 +: 8]);
    foreach (pay[i]) send_byte(pay[i]);
  endtask

  task automatic send_good_frame();
    logic [15:0] ver;
    int unsigned cap;
    int unsigned len;
    case ($urandom_range(0, 3))
      0: ver = 16'd1;
      1: ver = cur_sv;
      default: ver = 16'($urandom_range(1, cur_sv));
    endcase
    cap = (cur_mp < 48) ? cur_mp : 48;
    case ($urandom_range(0, 7))
      0: len = 0;
      1: len = cap;
      default: len = $urandom_range(0, cap);
    endcase
    send_frame(FrameMagic, ver, 16'($urandom), $urandom, len, rand_payload(len), 32'd0);
  endtask

  task automatic run_phase(input logic [15:0] sv, input logic [23:0] mp,
                           input int unsigned n_bytes);
    int unsigned start;
    wait_drained();
    write_cfg(CfgSupportedVersion, {8'd0, sv});
    write_cfg(CfgMaxPayload, mp);
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) send_good_frame();
  endtask

  // One terminal error ends the run, since the block only leaves the error phase on reset
  task automatic send_fatal_frame();
    logic [31:0] magic;
    logic [15:0] ver;
    logic [31:0] len;
    logic [31:0] flip;
    octet_q_t    pay;
    magic = FrameMagic;
    ver   = 16'($urandom_range(1, cur_sv));
    len   = 32'd0;
    flip  = 32'd0;
    case ($urandom_range(0, 5))
      0: magic = FrameMagic ^ (32'd1 << $urandom_range(0, 31));
      1: ver = (cur_sv == 16'hFFFF || $urandom_range(0, 1) == 0) ?
               16'd0 : 16'($urandom_range(cur_sv + 1, 16'hFFFF));
      2: begin
        // version register zero rejects any version
        write_cfg(CfgSupportedVersion, '0);
        ver = 16'($urandom);
      end
      3: len = (cur_mp == 24'hFF_FFFF || $urandom_range(0, 1) == 0) ?
               {8'($urandom_range(1, 255)), 24'($urandom)} :
               32'($urandom_range(cur_mp + 1, 24'hFF_FFFF));
      4: begin
        len  = $urandom_range(1, 16);
        pay  = rand_payload(len);
        flip = 32'd1 << $urandom_range(0, 31);
      end
      default: flip = 32'd1 << $urandom_range(0, 31);  // empty payload, bad CRC
    endcase
    send_frame(magic, ver, 16'($urandom), $urandom, len, pay, flip);
    repeat (30) send_byte(8'($urandom));
  endtask

  initial begin
    octet_q_t no_data;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    send_pct = 27;
    recv_pct = 67;
    // reset settings, empty frame carrying all-ones and all-zero bytes
    send_frame(FrameMagic, 16'd1, 16'hFFFF, 32'h0000_0000, 32'd0, no_data, 32'd0);
    run_phase(16'd1, 24'd48, 150);
    run_phase(16'hFFFF, 24'hFF_FFFF, 150);

    send_pct = 67;
    recv_pct = 27;
    run_phase(16'($urandom_range(2, 16'hFFFE)), 24'd0, 100);
    run_phase(16'($urandom_range(1, 16'hFFFF)), 24'($urandom_range(1, 47)), 150);

    send_pct = 0;
    recv_pct = 0;
    run_phase(16'hFFFF, 24'hFF_FFFF, 150);
    // long receiver hold-off while a frame keeps coming in
    hold_req = 1'b1;
    send_frame(FrameMagic, 16'd1, 16'($urandom), $urandom, 32'd48, rand_payload(48), 32'd0);
    run_phase(16'($urandom_range(1, 16'hFFFF)), 24'($urandom_range(64, 24'hFF_FFFF)), 120);

    wait_drained();
    send_fatal_frame();
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/fdc32c_pkg.sv
src/frame_deframer_crc32c_check.sv
tb/sv/tb_frame_deframer_crc32c_check.sv
